FILE: rtl/sfm_pkg.sv
// Shared types and constants of the sensor frame timestamp matcher.
`default_nettype none

package sfm_pkg;

  localparam int TIME_W     = 63;
  localparam int HANDLE_W   = 16;
  localparam int TOL_W      = 32;
  localparam int SENSOR_W   = 3;
  localparam int OPCODE_W   = 2;
  localparam int PADDR_W    = 3;
  localparam int PDATA_W    = 32;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W     = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W     = $clog2(QUEUE_DEPTH + 1);

  localparam logic [TOL_W-1:0] TOL_RESET = 32'd100000;

  // Register index, taken from the word address on the configuration port.
  localparam logic REG_TOLERANCE = 1'b0;

  typedef enum logic [OPCODE_W-1:0] {
    OP_PUSH   = 2'd0,
    OP_LATEST = 2'd1,
    OP_MATCH  = 2'd2,
    OP_PAIR   = 2'd3
  } op_t;

  // One classified command as it sits in the queue between front and back.
  typedef struct packed {
    op_t                 op;
    logic                sensor_ok;
    logic                second_ok;
    logic [SENSOR_W-1:0] sensor;
    logic [SENSOR_W-1:0] second_sensor;
    logic [TIME_W-1:0]   timestamp;
    logic [HANDLE_W-1:0] handle;
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INFO,
    ST_INFO_B,
    ST_PUSH,
    ST_LATEST,
    ST_LATEST_RD,
    ST_MATCH,
    ST_LOAD_B,
    ST_SCAN_A,
    ST_EMIT
  } back_state_t;

endpackage

`default_nettype wire

FILE: rtl/sfm_front.sv
// Front end: accepts input beats, classifies them and queues them for the back end.
`default_nettype none

module sfm_front #(
  parameter int SENSOR_COUNT = 8
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          item_valid,
  output logic                               item_stall,
  input  wire logic [sfm_pkg::OPCODE_W-1:0]  opcode,
  input  wire logic [sfm_pkg::SENSOR_W-1:0]  sensor,
  input  wire logic [sfm_pkg::SENSOR_W-1:0]  second_sensor,
  input  wire logic [sfm_pkg::TIME_W-1:0]    timestamp,
  input  wire logic [sfm_pkg::HANDLE_W-1:0]  frame_handle,
  output logic                               cmd_valid,
  output sfm_pkg::cmd_t                      cmd,
  input  wire logic                          cmd_pop
);

  sfm_pkg::cmd_t                    queue [sfm_pkg::QUEUE_DEPTH];
  logic [sfm_pkg::QPTR_W-1:0]       wr_ptr;
  logic [sfm_pkg::QPTR_W-1:0]       rd_ptr;
  logic [sfm_pkg::QCNT_W-1:0]       count;
  logic                             push;
  logic                             pop;
  sfm_pkg::cmd_t                    incoming;

  assign item_stall = (count == sfm_pkg::QCNT_W'(sfm_pkg::QUEUE_DEPTH));
  assign push       = item_valid && !item_stall;
  assign pop        = cmd_pop && cmd_valid;
  assign cmd_valid  = (count != '0);
  assign cmd        = queue[rd_ptr];

  // A sensor index past the configured count is flagged here so the back end
  // treats it as an empty sensor.
  always_comb begin
    incoming.op            = sfm_pkg::op_t'(opcode);
    incoming.sensor_ok     = (int'(sensor) < SENSOR_COUNT);
    incoming.second_ok     = (int'(second_sensor) < SENSOR_COUNT);
    incoming.sensor        = sensor;
    incoming.second_sensor = second_sensor;
    incoming.timestamp     = timestamp;
    incoming.handle        = frame_handle;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == sfm_pkg::QPTR_W'(sfm_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == sfm_pkg::QPTR_W'(sfm_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= incoming;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/sfm_back.sv
// Back end: frame history memory, per-sensor ring counters, search sequencer and result register.
`default_nettype none

module sfm_back #(
  parameter int SENSOR_COUNT  = 8,
  parameter int HISTORY_DEPTH = 5
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cmd_valid,
  input  wire sfm_pkg::cmd_t                 cmd,
  output logic                               cmd_pop,
  input  wire logic [sfm_pkg::TOL_W-1:0]     tolerance_ticks,
  output logic                               result_valid,
  input  wire logic                          result_stall,
  output logic                               found,
  output logic [sfm_pkg::HANDLE_W-1:0]       result_handle,
  output logic [sfm_pkg::TIME_W-1:0]         result_time
);

  localparam int SIDX_W    = (SENSOR_COUNT > 1) ? $clog2(SENSOR_COUNT) : 1;
  localparam int SLOT_W    = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int CNT_W     = $clog2(HISTORY_DEPTH + 1);
  localparam int MEM_DEPTH = SENSOR_COUNT * HISTORY_DEPTH;
  localparam int ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

  // Physical slot of the k-th oldest entry; base and k together stay below
  // twice the depth, so one compare and subtract wraps the sum.
  function automatic logic [SLOT_W-1:0] wrap_slot(input logic [SLOT_W-1:0] base,
                                                  input logic [CNT_W-1:0]  k);
    logic [CNT_W:0] sum;
    sum = (CNT_W+1)'(base) + (CNT_W+1)'(k);
    if (sum >= (CNT_W+1)'(HISTORY_DEPTH)) begin
      sum = sum - (CNT_W+1)'(HISTORY_DEPTH);
    end
    return sum[SLOT_W-1:0];
  endfunction

  function automatic logic [ADDR_W-1:0] mem_addr(input logic [SIDX_W-1:0] idx,
                                                 input logic [SLOT_W-1:0] slot);
    return ADDR_W'(ADDR_W'(idx) * ADDR_W'(HISTORY_DEPTH) + ADDR_W'(slot));
  endfunction

  // Strict test |a - b| < tolerance.
  function automatic logic within_tol(input logic [sfm_pkg::TIME_W-1:0] a,
                                      input logic [sfm_pkg::TIME_W-1:0] b,
                                      input logic [sfm_pkg::TOL_W-1:0]  tol);
    logic [sfm_pkg::TIME_W-1:0] diff;
    diff = (a >= b) ? (a - b) : (b - a);
    return diff < sfm_pkg::TIME_W'(tol);
  endfunction

  sfm_pkg::back_state_t state;
  sfm_pkg::back_state_t state_next;

  logic [sfm_pkg::TIME_W-1:0]   time_mem   [MEM_DEPTH];
  logic [sfm_pkg::HANDLE_W-1:0] handle_mem [MEM_DEPTH];
  logic [sfm_pkg::TIME_W-1:0]   rd_time;
  logic [sfm_pkg::HANDLE_W-1:0] rd_handle;
  logic [ADDR_W-1:0]            rd_addr;
  logic [ADDR_W-1:0]            wr_addr;
  logic                         mem_we;

  logic [CNT_W-1:0]             fill   [SENSOR_COUNT];
  logic [SLOT_W-1:0]            oldest [SENSOR_COUNT];

  sfm_pkg::cmd_t                cur;
  logic [SIDX_W-1:0]            a_idx;
  logic [SIDX_W-1:0]            b_idx;
  logic [SIDX_W-1:0]            info_idx;
  logic [CNT_W-1:0]             info_fill;
  logic [SLOT_W-1:0]            info_oldest;
  logic [CNT_W-1:0]             a_fill_eff;
  logic [CNT_W-1:0]             fill_a;
  logic [SLOT_W-1:0]            oldest_a;
  logic [CNT_W-1:0]             fill_b;
  logic [SLOT_W-1:0]            oldest_b;
  logic                         ring_full;
  logic [SLOT_W-1:0]            push_slot;

  logic [CNT_W-1:0]             issue_k;
  logic [CNT_W-1:0]             ld_k;
  logic                         issuing;
  logic                         pend;
  logic                         pend_next;

  logic [sfm_pkg::TIME_W-1:0]   tb [HISTORY_DEPTH];
  logic [HISTORY_DEPTH-1:0]     row_hit;
  logic                         row_any;
  logic                         match_hit;

  logic                         res_found;
  logic [sfm_pkg::HANDLE_W-1:0] res_handle;
  logic [sfm_pkg::TIME_W-1:0]   res_time;
  logic                         emit_ok;

  assign a_idx       = cur.sensor_ok ? SIDX_W'(cur.sensor) : '0;
  assign b_idx       = cur.second_ok ? SIDX_W'(cur.second_sensor) : '0;
  assign info_fill   = fill[info_idx];
  assign info_oldest = oldest[info_idx];
  assign a_fill_eff  = cur.sensor_ok ? info_fill : '0;
  assign ring_full   = (fill_a >= CNT_W'(HISTORY_DEPTH));
  assign push_slot   = ring_full ? oldest_a : wrap_slot(oldest_a, fill_a);
  assign match_hit   = within_tol(cur.timestamp, rd_time, tolerance_ticks);
  assign emit_ok     = !result_valid || !result_stall;

  // One row of comparators: the A entry just read against every loaded B entry.
  always_comb begin
    for (int j = 0; j < HISTORY_DEPTH; j++) begin
      row_hit[j] = (CNT_W'(j) < fill_b) && within_tol(rd_time, tb[j], tolerance_ticks);
    end
  end
  assign row_any = |row_hit;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      sfm_pkg::ST_IDLE: begin
        if (cmd_valid) begin
          state_next = sfm_pkg::ST_INFO;
        end
      end
      sfm_pkg::ST_INFO: begin
        case (cur.op)
          sfm_pkg::OP_PUSH:   state_next = cur.sensor_ok ? sfm_pkg::ST_PUSH : sfm_pkg::ST_IDLE;
          sfm_pkg::OP_LATEST: state_next = (a_fill_eff == '0) ? sfm_pkg::ST_EMIT
                                                              : sfm_pkg::ST_LATEST;
          sfm_pkg::OP_MATCH:  state_next = sfm_pkg::ST_MATCH;
          default:            state_next = sfm_pkg::ST_INFO_B;
        endcase
      end
      sfm_pkg::ST_INFO_B:    state_next = sfm_pkg::ST_LOAD_B;
      sfm_pkg::ST_PUSH:      state_next = sfm_pkg::ST_IDLE;
      sfm_pkg::ST_LATEST:    state_next = sfm_pkg::ST_LATEST_RD;
      sfm_pkg::ST_LATEST_RD: state_next = sfm_pkg::ST_EMIT;
      sfm_pkg::ST_MATCH: begin
        if ((pend && match_hit) || (!pend && !issuing)) begin
          state_next = sfm_pkg::ST_EMIT;
        end
      end
      sfm_pkg::ST_LOAD_B: begin
        if (!pend && !issuing) begin
          state_next = sfm_pkg::ST_SCAN_A;
        end
      end
      sfm_pkg::ST_SCAN_A: begin
        if (!pend && !issuing) begin
          state_next = sfm_pkg::ST_EMIT;
        end
      end
      sfm_pkg::ST_EMIT: begin
        if (emit_ok) begin
          state_next = sfm_pkg::ST_IDLE;
        end
      end
      default: state_next = sfm_pkg::ST_IDLE;
    endcase
  end

  // State outputs: queue pop, memory addresses and the read issue control.
  always_comb begin
    cmd_pop  = 1'b0;
    mem_we   = 1'b0;
    wr_addr  = mem_addr(a_idx, push_slot);
    rd_addr  = '0;
    issuing  = 1'b0;
    info_idx = a_idx;
    case (state)
      sfm_pkg::ST_IDLE:   cmd_pop = cmd_valid;
      sfm_pkg::ST_INFO_B: info_idx = b_idx;
      sfm_pkg::ST_PUSH:   mem_we = 1'b1;
      sfm_pkg::ST_LATEST: rd_addr = mem_addr(a_idx, wrap_slot(oldest_a, fill_a - 1'b1));
      sfm_pkg::ST_MATCH, sfm_pkg::ST_SCAN_A: begin
        issuing = (issue_k < fill_a);
        rd_addr = mem_addr(a_idx, wrap_slot(oldest_a, issue_k));
      end
      sfm_pkg::ST_LOAD_B: begin
        issuing = (issue_k < fill_b);
        rd_addr = mem_addr(b_idx, wrap_slot(oldest_b, issue_k));
      end
      default: begin
        cmd_pop = 1'b0;
      end
    endcase
    pend_next = issuing;
  end

  // Control state: sequencer, ring counters, result valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= sfm_pkg::ST_IDLE;
      pend         <= 1'b0;
      result_valid <= 1'b0;
      for (int s = 0; s < SENSOR_COUNT; s++) begin
        fill[s]   <= '0;
        oldest[s] <= '0;
      end
    end else begin
      state <= state_next;
      pend  <= pend_next;
      if (state == sfm_pkg::ST_EMIT && emit_ok) begin
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      if (state == sfm_pkg::ST_PUSH) begin
        if (ring_full) begin
          oldest[a_idx] <= wrap_slot(oldest_a, CNT_W'(1));
        end else begin
          fill[a_idx] <= fill_a + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      time_mem[wr_addr]   <= cur.timestamp;
      handle_mem[wr_addr] <= cur.handle;
    end
    rd_time   <= time_mem[rd_addr];
    rd_handle <= handle_mem[rd_addr];
  end

  // Working registers of the current command.
  always_ff @(posedge clk) begin
    case (state)
      sfm_pkg::ST_IDLE: begin
        if (cmd_valid) begin
          cur <= cmd;
        end
      end
      sfm_pkg::ST_INFO: begin
        fill_a     <= a_fill_eff;
        oldest_a   <= info_oldest;
        res_found  <= 1'b0;
        res_handle <= '0;
        res_time   <= '0;
        issue_k    <= '0;
        ld_k       <= '0;
      end
      sfm_pkg::ST_INFO_B: begin
        fill_b   <= (cur.sensor_ok && cur.second_ok) ? info_fill : '0;
        oldest_b <= info_oldest;
      end
      sfm_pkg::ST_LATEST_RD: begin
        res_found  <= 1'b1;
        res_handle <= rd_handle;
        res_time   <= rd_time;
      end
      sfm_pkg::ST_MATCH: begin
        if (issuing) begin
          issue_k <= issue_k + 1'b1;
        end
        if (pend && match_hit) begin
          res_found  <= 1'b1;
          res_handle <= rd_handle;
          res_time   <= rd_time;
        end
      end
      sfm_pkg::ST_LOAD_B: begin
        if (issuing) begin
          issue_k <= issue_k + 1'b1;
        end else if (!pend) begin
          issue_k <= '0;
        end
        if (pend) begin
          tb[ld_k[SLOT_W-1:0]] <= rd_time;
          ld_k <= ld_k + 1'b1;
        end
      end
      sfm_pkg::ST_SCAN_A: begin
        if (issuing) begin
          issue_k <= issue_k + 1'b1;
        end
        // A strictly larger time is always nonzero, so found follows the best time.
        if (pend && row_any && (rd_time > res_time)) begin
          res_found <= 1'b1;
          res_time  <= rd_time;
        end
      end
      sfm_pkg::ST_EMIT: begin
        if (emit_ok) begin
          found         <= res_found;
          result_handle <= res_handle;
          result_time   <= res_time;
        end
      end
      default: begin
        issue_k <= issue_k;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/sensor_frame_timestamp_matcher.sv
// Top level of the sensor frame timestamp matcher: configuration port, front end and back end.
//
// Usage: commands arrive as beats on the item channel (item_valid/item_stall) with
// opcode, sensor, second_sensor, timestamp and frame_handle. A push stores a frame in
// the sensor's five-deep history and returns no beat; latest, match-time and pair
// search each return one beat on the result channel (result_valid/result_stall).
// tolerance_ticks is written at byte address 0 of the APB port. The user must write it
// only while the block is idle; the block itself does not enforce this. A two-beat queue
// decouples the input side from the search engine, so new commands are taken while a
// search runs or a result waits. A latest search skips the memory read when the history
// is empty, and a match-time search ends at its first hit. The history memory has a
// single read port, which delivers one entry per cycle; a pair search loads every B
// entry, then compares each A entry as it is read against all loaded B entries at once.
// Each result passes through an output register.
// Reset empties all histories and the queue and restores the tolerance to 100000;
// history memory contents are not cleared. A stalled result holds its beat and the
// engine waits behind it, after which the queue fills and item_stall rises.
`default_nettype none

module sensor_frame_timestamp_matcher #(
  parameter int SENSOR_COUNT  = 8,
  parameter int HISTORY_DEPTH = 5
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [sfm_pkg::PADDR_W-1:0]   paddr,
  input  wire logic [sfm_pkg::PDATA_W-1:0]   pwdata,
  output logic      [sfm_pkg::PDATA_W-1:0]   prdata,
  output logic                               pready,
  input  wire logic                          item_valid,
  output logic                               item_stall,
  input  wire logic [sfm_pkg::OPCODE_W-1:0]  opcode,
  input  wire logic [sfm_pkg::SENSOR_W-1:0]  sensor,
  input  wire logic [sfm_pkg::SENSOR_W-1:0]  second_sensor,
  input  wire logic [sfm_pkg::TIME_W-1:0]    timestamp,
  input  wire logic [sfm_pkg::HANDLE_W-1:0]  frame_handle,
  output logic                               result_valid,
  input  wire logic                          result_stall,
  output logic                               found,
  output logic [sfm_pkg::HANDLE_W-1:0]       result_handle,
  output logic [sfm_pkg::TIME_W-1:0]         result_time
);

  logic [sfm_pkg::TOL_W-1:0] tolerance_ticks;
  logic                      reg_hit;
  logic                      cmd_valid;
  logic                      cmd_pop;
  sfm_pkg::cmd_t             cmd;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[2] == sfm_pkg::REG_TOLERANCE);
  assign prdata  = reg_hit ? sfm_pkg::PDATA_W'(tolerance_ticks) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      tolerance_ticks <= sfm_pkg::TOL_RESET;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      tolerance_ticks <= sfm_pkg::TOL_W'(pwdata);
    end
  end

  sfm_front #(
    .SENSOR_COUNT (SENSOR_COUNT)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .item_valid    (item_valid),
    .item_stall    (item_stall),
    .opcode        (opcode),
    .sensor        (sensor),
    .second_sensor (second_sensor),
    .timestamp     (timestamp),
    .frame_handle  (frame_handle),
    .cmd_valid     (cmd_valid),
    .cmd           (cmd),
    .cmd_pop       (cmd_pop)
  );

  sfm_back #(
    .SENSOR_COUNT  (SENSOR_COUNT),
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .cmd_valid       (cmd_valid),
    .cmd             (cmd),
    .cmd_pop         (cmd_pop),
    .tolerance_ticks (tolerance_ticks),
    .result_valid    (result_valid),
    .result_stall    (result_stall),
    .found           (found),
    .result_handle   (result_handle),
    .result_time     (result_time)
  );

endmodule

`default_nettype wire

FILE: sim/sensor_frame_timestamp_matcher_tb.sv
// Self-checking testbench for the sensor frame timestamp matcher: directed table, random traffic.
`default_nettype none

module sensor_frame_timestamp_matcher_tb;

  localparam int NUM_SENSORS  = 8;
  localparam int RING_DEPTH   = 5;
  localparam int PHASE_ITEMS  = 240;
  localparam int DRAIN_CYCLES = 32;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int POOL_SIZE    = 16;
  localparam int ANSWER_SLOTS = 16;

  localparam logic [sfm_pkg::PADDR_W-1:0] ADDR_TOL   = {sfm_pkg::REG_TOLERANCE, 2'b00};
  localparam logic [sfm_pkg::PADDR_W-1:0] ADDR_SPARE = 3'd4;
  localparam logic [sfm_pkg::TIME_W-1:0]  TS_TOP     = {sfm_pkg::TIME_W{1'b1}};

  typedef struct packed {
    logic                         found;
    logic [sfm_pkg::HANDLE_W-1:0] handle;
    logic [sfm_pkg::TIME_W-1:0]   stamp;
  } answer_t;

  typedef struct packed {
    sfm_pkg::op_t                 op;
    logic [sfm_pkg::SENSOR_W-1:0] sensor_a;
    logic [sfm_pkg::SENSOR_W-1:0] sensor_b;
    logic [sfm_pkg::TIME_W-1:0]   stamp;
    logic [sfm_pkg::HANDLE_W-1:0] handle;
    logic                         typed;
    answer_t                      ans;
  } plan_row_t;

  localparam answer_t NO_HIT = '0;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [sfm_pkg::PADDR_W-1:0] paddr = '0;
  logic [sfm_pkg::PDATA_W-1:0] pwdata = '0;
  logic [sfm_pkg::PDATA_W-1:0] prdata;
  logic pready;
  logic item_valid = 1'b0;
  logic item_stall;
  logic [sfm_pkg::OPCODE_W-1:0] opcode = '0;
  logic [sfm_pkg::SENSOR_W-1:0] sensor = '0;
  logic [sfm_pkg::SENSOR_W-1:0] second_sensor = '0;
  logic [sfm_pkg::TIME_W-1:0] timestamp = '0;
  logic [sfm_pkg::HANDLE_W-1:0] frame_handle = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  logic found;
  logic [sfm_pkg::HANDLE_W-1:0] result_handle;
  logic [sfm_pkg::TIME_W-1:0] result_time;

  sensor_frame_timestamp_matcher dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .item_valid(item_valid), .item_stall(item_stall),
    .opcode(opcode), .sensor(sensor), .second_sensor(second_sensor),
    .timestamp(timestamp), .frame_handle(frame_handle),
    .result_valid(result_valid), .result_stall(result_stall),
    .found(found), .result_handle(result_handle), .result_time(result_time)
  );

  always #6 clk = ~clk;

  // Mirror of the frame histories and the tolerance register.
  logic [sfm_pkg::TIME_W-1:0]   ring_time [NUM_SENSORS][RING_DEPTH];
  logic [sfm_pkg::HANDLE_W-1:0] ring_handle [NUM_SENSORS][RING_DEPTH];
  int                           ring_fill [NUM_SENSORS];
  int                           ring_oldest [NUM_SENSORS];
  logic [sfm_pkg::TOL_W-1:0]    tol_now = sfm_pkg::TOL_RESET;

  // Expected answers in order, kept in a ring with running write and read counts.
  answer_t                    answer_log [ANSWER_SLOTS];
  int                         log_wr = 0;
  int                         log_rd = 0;
  answer_t                    oldest_answer;
  // Recently pushed times, reused as query times.
  logic [sfm_pkg::TIME_W-1:0] time_pool [POOL_SIZE];
  int                         pool_fill = 0;
  int                         pool_next = 0;
  logic [sfm_pkg::TIME_W-1:0] phase_base = '0;

  bit quiet = 1'b0;
  bit sender_idle = 1'b1;
  int stall_left = 0;
  int cycle_count = 0;
  int mismatches = 0;
  int n_push = 0;
  int n_query = 0;
  int n_checked = 0;
  int n_hits = 0;
  int n_settings = 1;

  task automatic flag_mismatch(input string what);
    $display("MISMATCH cycle %0d: %s", cycle_count, what);
    mismatches++;
  endtask

  // Applies one command to the mirrored histories and works out its answer.
  task automatic history_apply(input sfm_pkg::op_t op,
                               input logic [sfm_pkg::SENSOR_W-1:0] sa,
                               input logic [sfm_pkg::SENSOR_W-1:0] sb,
                               input logic [sfm_pkg::TIME_W-1:0] ts,
                               input logic [sfm_pkg::HANDLE_W-1:0] hd, output bit gives,
                               output answer_t ans);
    int slot;
    logic [sfm_pkg::TIME_W-1:0] ta;
    logic [sfm_pkg::TIME_W-1:0] tb;
    logic [sfm_pkg::TIME_W-1:0] diff;
    logic [sfm_pkg::TIME_W-1:0] best;
    ans = NO_HIT;
    gives = 1'b1;
    case (op)
      sfm_pkg::OP_PUSH: begin
        gives = 1'b0;
        if (ring_fill[sa] < RING_DEPTH) begin
          slot = (ring_oldest[sa] + ring_fill[sa]) % RING_DEPTH;
          ring_fill[sa]++;
        end else begin
          slot = ring_oldest[sa];
          ring_oldest[sa] = (ring_oldest[sa] + 1) % RING_DEPTH;
        end
        ring_time[sa][slot] = ts;
        ring_handle[sa][slot] = hd;
      end
      sfm_pkg::OP_LATEST: begin
        if (ring_fill[sa] > 0) begin
          slot = (ring_oldest[sa] + ring_fill[sa] - 1) % RING_DEPTH;
          ans = '{1'b1, ring_handle[sa][slot], ring_time[sa][slot]};
        end
      end
      sfm_pkg::OP_MATCH: begin
        for (int k = 0; k < ring_fill[sa]; k++) begin
          slot = (ring_oldest[sa] + k) % RING_DEPTH;
          ta = ring_time[sa][slot];
          diff = (ts > ta) ? ts - ta : ta - ts;
          if (!ans.found && diff < {{(sfm_pkg::TIME_W-sfm_pkg::TOL_W){1'b0}}, tol_now})
            ans = '{1'b1, ring_handle[sa][slot], ta};
        end
      end
      default: begin
        best = '0;
        for (int k = 0; k < ring_fill[sa]; k++) begin
          ta = ring_time[sa][(ring_oldest[sa] + k) % RING_DEPTH];
          for (int j = 0; j < ring_fill[sb]; j++) begin
            tb = ring_time[sb][(ring_oldest[sb] + j) % RING_DEPTH];
            diff = (ta > tb) ? ta - tb : tb - ta;
            if (diff < {{(sfm_pkg::TIME_W-sfm_pkg::TOL_W){1'b0}}, tol_now} && ta > best)
              best = ta;
          end
        end
        ans = '{best != '0, '0, best};
      end
    endcase
  endtask

  // Holds the beat until it is taken, then records what it should produce.
  task automatic send_cmd(input sfm_pkg::op_t op, input logic [sfm_pkg::SENSOR_W-1:0] sa,
                          input logic [sfm_pkg::SENSOR_W-1:0] sb,
                          input logic [sfm_pkg::TIME_W-1:0] ts,
                          input logic [sfm_pkg::HANDLE_W-1:0] hd, input logic typed,
                          input answer_t typed_ans);
    bit gives;
    answer_t ans;
    item_valid <= 1'b1;
    opcode <= op;
    sensor <= sa;
    second_sensor <= sb;
    timestamp <= ts;
    frame_handle <= hd;
    do @(posedge clk); while (item_stall);
    history_apply(op, sa, sb, ts, hd, gives, ans);
    if (gives) begin
      answer_log[log_wr % ANSWER_SLOTS] = typed ? typed_ans : ans;
      log_wr++;
      n_query++;
    end else begin
      n_push++;
      time_pool[pool_next] = ts;
      pool_next = (pool_next + 1) % POOL_SIZE;
      if (pool_fill < POOL_SIZE) pool_fill++;
    end
    if (!quiet && sender_idle && $urandom_range(0, 3) == 0) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    while (log_wr != log_rd) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [sfm_pkg::PADDR_W-1:0] addr,
                           input logic [sfm_pkg::PDATA_W-1:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (addr == ADDR_TOL) tol_now = data;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic cfg_check_tolerance();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= ADDR_TOL;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== tol_now)
      flag_mismatch($sformatf("tolerance reads %0d, expected %0d", prdata, tol_now));
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Query times cluster around stored frames and the tolerance edges so that hits are common.
  function automatic logic [sfm_pkg::TIME_W-1:0] choose_time();
    logic [63:0] t;
    logic [63:0] offs;
    logic [31:0] span;
    t = {32'd0, $urandom};
    case ($urandom_range(0, 9))
      0: t = {$urandom, $urandom};
      1: t = $urandom_range(0, 1) ? {1'b0, TS_TOP} : 64'd0;
      2, 3: begin
        if (pool_fill == 0) begin
          t = {1'b0, phase_base};
        end else begin
          t = {1'b0, time_pool[$urandom_range(0, pool_fill - 1)]};
          case ($urandom_range(0, 4))
            0: offs = 64'd0;
            1: offs = 64'd1;
            2: offs = {32'd0, tol_now} - 64'd1;
            3: offs = {32'd0, tol_now};
            default: offs = {32'd0, tol_now} + 64'd1;
          endcase
          t = $urandom_range(0, 1) ? t + offs : t - offs;
        end
      end
      default: begin
        if (tol_now == '0) span = 32'd1000;
        else if (tol_now >= 32'h4000_0000) span = 32'hFFFF_FFFF;
        else span = tol_now * 3;
        t = {1'b0, phase_base} + {32'd0, $urandom_range(0, span)};
      end
    endcase
    return t[sfm_pkg::TIME_W-1:0];
  endfunction

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d answers outstanding",
               cycle_count, log_wr - log_rd);
      $display("Regression FAIL");
      $finish;
    end
  end

  // Result side: checks every taken beat and stalls in random bursts.
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      if (log_wr == log_rd) begin
        flag_mismatch("result beat with no answer awaited");
      end else begin
        oldest_answer = answer_log[log_rd % ANSWER_SLOTS];
        log_rd++;
        n_checked++;
        if (oldest_answer.found) n_hits++;
        if (found !== oldest_answer.found)
          flag_mismatch($sformatf("found %0b, expected %0b", found, oldest_answer.found));
        if (result_handle !== oldest_answer.handle)
          flag_mismatch($sformatf("result_handle %h, expected %h",
                                  result_handle, oldest_answer.handle));
        if (result_time !== oldest_answer.stamp)
          flag_mismatch($sformatf("result_time %h, expected %h",
                                  result_time, oldest_answer.stamp));
      end
    end
    if (stall_left != 0) begin
      result_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else begin
      result_stall <= 1'b0;
      if (!quiet && $urandom_range(0, 5) == 0) stall_left <= $urandom_range(1, 9);
    end
  end

  initial begin : stimulus
    plan_row_t plan [26];
    logic [sfm_pkg::TOL_W-1:0] tol_plan [7];
    int pick;
    sfm_pkg::op_t op;
    logic [sfm_pkg::SENSOR_W-1:0] sa;

    plan = '{
      '{sfm_pkg::OP_LATEST, 3'd0, 3'd0, 63'd0, 16'd0, 1'b1, NO_HIT},
      '{sfm_pkg::OP_MATCH,  3'd0, 3'd0, 63'd0, 16'd0, 1'b1, NO_HIT},
      '{sfm_pkg::OP_PAIR,   3'd0, 3'd1, 63'd0, 16'd0, 1'b1, NO_HIT},
      '{sfm_pkg::OP_PUSH,   3'd0, 3'd0, TS_TOP, 16'hFFFF, 1'b0, NO_HIT},
      '{sfm_pkg::OP_LATEST, 3'd0, 3'd0, 63'd0, 16'd0, 1'b1, '{1'b1, 16'hFFFF, TS_TOP}},
      '{sfm_pkg::OP_PUSH,   3'd1, 3'd0, 63'd0, 16'd0, 1'b0, NO_HIT},
      '{sfm_pkg::OP_LATEST, 3'd1, 3'd0, 63'd0, 16'd0, 1'b1, '{1'b1, 16'd0, 63'd0}},
      // A pair that matches at time zero still reports nothing found.
      '{sfm_pkg::OP_PAIR,   3'd1, 3'd1, 63'd0, 16'd0, 1'b1, NO_HIT},
      '{sfm_pkg::OP_MATCH,  3'd1, 3'd0, 63'd99999, 16'd0, 1'b1, '{1'b1, 16'd0, 63'd0}},
      '{sfm_pkg::OP_MATCH,  3'd1, 3'd0, 63'd100000, 16'd0, 1'b1, NO_HIT},
      '{sfm_pkg::OP_PAIR,   3'd0, 3'd1, 63'd0, 16'd0, 1'b1, NO_HIT},
      '{sfm_pkg::OP_PUSH,   3'd0, 3'd0, TS_TOP - 63'd50, 16'h1234, 1'b0, NO_HIT},
      '{sfm_pkg::OP_PAIR,   3'd0, 3'd0, 63'd0, 16'd0, 1'b0, NO_HIT},
      '{sfm_pkg::OP_PUSH,   3'd2, 3'd0, 63'd1000, 16'd1, 1'b0, NO_HIT},
      '{sfm_pkg::OP_PUSH,   3'd2, 3'd0, 63'd2000, 16'd2, 1'b0, NO_HIT},
      '{sfm_pkg::OP_PUSH,   3'd2, 3'd0, 63'd3000, 16'd3, 1'b0, NO_HIT},
      '{sfm_pkg::OP_PUSH,   3'd2, 3'd0, 63'd4000, 16'd4, 1'b0, NO_HIT},
      '{sfm_pkg::OP_PUSH,   3'd2, 3'd0, 63'd5000, 16'd5, 1'b0, NO_HIT},
      '{sfm_pkg::OP_PUSH,   3'd2, 3'd0, 63'd6000, 16'd6, 1'b0, NO_HIT},
      '{sfm_pkg::OP_LATEST, 3'd2, 3'd0, 63'd0, 16'd0, 1'b1, '{1'b1, 16'd6, 63'd6000}},
      '{sfm_pkg::OP_MATCH,  3'd2, 3'd0, 63'd0, 16'd0, 1'b0, NO_HIT},
      '{sfm_pkg::OP_PAIR,   3'd7, 3'd2, 63'd0, 16'd0, 1'b1, NO_HIT},
      '{sfm_pkg::OP_PUSH,   3'd7, 3'd0, 63'd3500, 16'hA5A5, 1'b0, NO_HIT},
      '{sfm_pkg::OP_PAIR,   3'd2, 3'd7, 63'd0, 16'd0, 1'b0, NO_HIT},
      '{sfm_pkg::OP_LATEST, 3'd7, 3'd7, 63'd0, 16'd0, 1'b0, NO_HIT},
      '{sfm_pkg::OP_MATCH,  3'd2, 3'd0, TS_TOP, 16'd0, 1'b1, NO_HIT}
    };
    tol_plan = '{32'd0, 32'd1, 32'hFFFF_FFFF, $urandom, sfm_pkg::TOL_RESET, 32'd37,
                 $urandom_range(2, 5000)};

    for (int s = 0; s < NUM_SENSORS; s++) begin
      ring_fill[s] = 0;
      ring_oldest[s] = 0;
    end

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i])
      send_cmd(plan[i].op, plan[i].sensor_a, plan[i].sensor_b, plan[i].stamp,
               plan[i].handle, plan[i].typed, plan[i].ans);
    item_valid <= 1'b0;
    wait_idle();

    // A write past the last register must leave the tolerance alone.
    cfg_write(ADDR_SPARE, $urandom);
    cfg_check_tolerance();

    foreach (tol_plan[p]) begin
      cfg_write(ADDR_TOL, tol_plan[p]);
      cfg_check_tolerance();
      n_settings++;
      phase_base = sfm_pkg::TIME_W'({$urandom, $urandom} >> 2);
      quiet = (p == $size(tol_plan) - 1);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (i % 40 == 0) sender_idle = $urandom_range(0, 2) != 0;
        pick = $urandom_range(0, 19);
        if (pick < 8) op = sfm_pkg::OP_PUSH;
        else if (pick < 11) op = sfm_pkg::OP_LATEST;
        else if (pick < 16) op = sfm_pkg::OP_MATCH;
        else op = sfm_pkg::OP_PAIR;
        // Most traffic lands on four sensors so that histories fill and wrap.
        sa = ($urandom_range(0, 3) == 0) ? sfm_pkg::SENSOR_W'($urandom_range(0, 7))
                                         : sfm_pkg::SENSOR_W'($urandom_range(0, 3));
        send_cmd(op, sa, ($urandom_range(0, 3) == 0) ? sfm_pkg::SENSOR_W'($urandom_range(0, 7))
                                                    : sfm_pkg::SENSOR_W'($urandom_range(0, 3)),
                 choose_time(), sfm_pkg::HANDLE_W'($urandom_range(0, 16'hFFFF)), 1'b0,
                 NO_HIT);
      end
      item_valid <= 1'b0;
      wait_idle();
    end

    $display("Ran %0d commands (%0d pushes, %0d queries) under %0d tolerance settings.",
             n_push + n_query, n_push, n_query, n_settings);
    $display("Checked %0d result beats, %0d of them hits; %0d mismatches.",
             n_checked, n_hits, mismatches);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: filelist.f
rtl/sfm_pkg.sv
rtl/sfm_front.sv
rtl/sfm_back.sv
rtl/sensor_frame_timestamp_matcher.sv
sim/sensor_frame_timestamp_matcher_tb.sv
